>>> hdl/bridge_adc_serial_readout_top_macros.svh
// Assertion macros shared by the readout sequencer RTL.
// No dependencies; include by bare file name.
`ifndef BRIDGE_ADC_SERIAL_READOUT_TOP_MACROS_SVH
`define BRIDGE_ADC_SERIAL_READOUT_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define BRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define BRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/brs_pkg.sv
// Shared types and constants for the bridge ADC serial readout block.
// No dependencies.
package brs_pkg;

  localparam int DATA_BITS = 24;
  localparam int SAMPLE_W  = 24;
  localparam int BIT_W     = $clog2(DATA_BITS + 1);

  localparam logic [BIT_W-1:0] BIT_ONE  = 1;
  localparam logic [BIT_W-1:0] BIT_LAST = DATA_BITS[BIT_W-1:0];

  localparam logic [15:0] HALF_PERIOD_RESET   = 16'd1000;
  localparam logic [31:0] READY_TIMEOUT_RESET = 32'd500000000;

  // Register select, taken from address bit 2
  localparam logic REG_HALF_PERIOD   = 1'b0;
  localparam logic REG_READY_TIMEOUT = 1'b1;

  // Gain choice codes
  localparam logic [1:0] GAIN_ONE_PULSE    = 2'd0;
  localparam logic [1:0] GAIN_THREE_PULSES = 2'd2;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [31:0] ready_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       data_pin;
    logic [1:0] gain_select;
    logic       start_req;
  } item_t;

  typedef struct packed {
    logic                       busy_res;
    logic                       timed_out;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       done_res;
    logic                       clock_pin;
  } res_t;

endpackage

>>> hdl/bridge_adc_serial_readout_top.sv
// Top level of the bridge ADC serial readout: stream ports, input and result registers.
// Depends on brs_pkg, brs_cfg and brs_core.

// Each input item is one tick of the pin-timing sequencer and yields one result item
// (clock level, done, sample, timeout flag, busy) after this tick's update. The block
// takes one item every cycle while the result register drains; each item passes from the
// input register through the single-step sequencer update into the result register. A
// result left waiting does not block the next item as long as the result register drains.
// Write the half period and ready timeout registers only while no readout is in progress.
module bridge_adc_serial_readout_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // start_req[0], gain_select[2:1], data_pin[3], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // clock_pin[0], done_res[1], sample[25:2],
                                      // timed_out[26], busy_res[27], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  brs_pkg::cfg_t  cfg;
  brs_pkg::item_t in_q;
  brs_pkg::res_t  res;
  brs_pkg::res_t  out_q;
  logic           in_valid;
  logic           out_valid;
  logic           advance;

  brs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Step the sequencer when the held item has somewhere to go
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.start_req   <= s_axis_tdata[0];
      in_q.gain_select <= s_axis_tdata[2:1];
      in_q.data_pin    <= s_axis_tdata[3];
    end
  end

  brs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (in_q),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  // Padding bits of the input word are not used
  logic unused_pad;
  assign unused_pad = ^s_axis_tdata[7:4];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_q.busy_res, out_q.timed_out, out_q.sample,
                          out_q.done_res, out_q.clock_pin};

endmodule

>>> hdl/brs_cfg.sv
// APB-style register file: half period and ready timeout.
// Depends on brs_pkg.
module brs_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output brs_pkg::cfg_t cfg
);

  logic [15:0] half_period_ticks;
  logic [31:0] ready_timeout_ticks;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks   <= brs_pkg::HALF_PERIOD_RESET;
      ready_timeout_ticks <= brs_pkg::READY_TIMEOUT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        brs_pkg::REG_HALF_PERIOD:   half_period_ticks   <= pwdata[15:0];
        brs_pkg::REG_READY_TIMEOUT: ready_timeout_ticks <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      brs_pkg::REG_HALF_PERIOD:   prdata = {16'd0, half_period_ticks};
      brs_pkg::REG_READY_TIMEOUT: prdata = ready_timeout_ticks;
      default:                    prdata = 32'd0;
    endcase
  end

  // Address bits 1:0 are not decoded
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

  assign cfg.half_period_ticks   = half_period_ticks;
  assign cfg.ready_timeout_ticks = ready_timeout_ticks;

endmodule

>>> hdl/brs_core.sv
// Pin-timing sequencer: one state update per stepped item, result built alongside.
// Depends on brs_pkg and bridge_adc_serial_readout_top_macros.svh.
`include "bridge_adc_serial_readout_top_macros.svh"

module brs_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step_en,
  input  brs_pkg::item_t item,
  input  brs_pkg::cfg_t  cfg,
  output brs_pkg::res_t  res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW,
    PH_TRAIL_HIGH,
    PH_TRAIL_LOW
  } phase_t;

  phase_t                             phase, phase_next;
  logic [31:0]                        tick_count, tick_count_next;
  logic [brs_pkg::BIT_W-1:0]          bit_count, bit_count_next;
  logic [brs_pkg::DATA_BITS-1:0]      shift_value, shift_value_next;
  logic [1:0]                         pulses_left, pulses_left_next;
  logic                               timeout_seen, timeout_seen_next;
  logic                               clock_level, clock_level_next;
  logic signed [brs_pkg::SAMPLE_W-1:0] last_sample, last_sample_next;

  logic [31:0]               tick_inc;
  logic                      half_done;
  logic [brs_pkg::BIT_W-1:0] bit_inc;
  logic signed [31:0]        ext_value;
  logic                      done;

  assign tick_inc  = tick_count + 32'd1;
  assign half_done = tick_inc >= {16'd0, cfg.half_period_ticks};
  assign bit_inc   = bit_count + brs_pkg::BIT_ONE;
  assign ext_value = 32'(signed'(shift_value));

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_count_next    = bit_count;
    shift_value_next  = shift_value;
    pulses_left_next  = pulses_left;
    timeout_seen_next = timeout_seen;
    clock_level_next  = clock_level;
    last_sample_next  = last_sample;
    done              = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          clock_level_next  = 1'b0;
          phase_next        = PH_WAIT;
          tick_count_next   = 32'd0;
          bit_count_next    = '0;
          shift_value_next  = '0;
          timeout_seen_next = 1'b0;
          case (item.gain_select)
            brs_pkg::GAIN_ONE_PULSE:    pulses_left_next = 2'd1;
            brs_pkg::GAIN_THREE_PULSES: pulses_left_next = 2'd3;
            default:                    pulses_left_next = 2'd2;
          endcase
        end
      end
      PH_WAIT: begin
        if (!item.data_pin) begin
          clock_level_next = 1'b1;
          phase_next       = PH_HIGH;
          tick_count_next  = 32'd0;
        end else if (tick_inc >= cfg.ready_timeout_ticks) begin
          timeout_seen_next = 1'b1;
          clock_level_next  = 1'b1;
          phase_next        = PH_HIGH;
          tick_count_next   = 32'd0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_HIGH: begin
        tick_count_next = tick_inc;
        if (half_done) begin
          clock_level_next = 1'b0;
          phase_next       = PH_LOW;
          tick_count_next  = 32'd0;
        end
      end
      PH_LOW: begin
        tick_count_next = tick_inc;
        if (half_done) begin
          // Sample at the end of the low half, MSB first
          shift_value_next = {shift_value[brs_pkg::DATA_BITS-2:0], item.data_pin};
          bit_count_next   = bit_inc;
          clock_level_next = 1'b1;
          tick_count_next  = 32'd0;
          phase_next       = (bit_inc >= brs_pkg::BIT_LAST) ? PH_TRAIL_HIGH : PH_HIGH;
        end
      end
      PH_TRAIL_HIGH: begin
        tick_count_next = tick_inc;
        if (half_done) begin
          clock_level_next = 1'b0;
          phase_next       = PH_TRAIL_LOW;
          tick_count_next  = 32'd0;
        end
      end
      PH_TRAIL_LOW: begin
        tick_count_next = tick_inc;
        if (half_done) begin
          tick_count_next = 32'd0;
          if (pulses_left > 2'd1) begin
            pulses_left_next = pulses_left - 2'd1;
            clock_level_next = 1'b1;
            phase_next       = PH_TRAIL_HIGH;
          end else begin
            pulses_left_next = 2'd0;
            last_sample_next = timeout_seen ? '0 : ext_value[brs_pkg::SAMPLE_W-1:0];
            done             = 1'b1;
            phase_next       = PH_IDLE;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= 32'd0;
      bit_count    <= '0;
      shift_value  <= '0;
      pulses_left  <= 2'd0;
      timeout_seen <= 1'b0;
      clock_level  <= 1'b1;
      last_sample  <= '0;
    end else if (step_en) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_count    <= bit_count_next;
      shift_value  <= shift_value_next;
      pulses_left  <= pulses_left_next;
      timeout_seen <= timeout_seen_next;
      clock_level  <= clock_level_next;
      last_sample  <= last_sample_next;
    end
  end

  assign res.clock_pin = clock_level_next;
  assign res.done_res  = done;
  assign res.sample    = last_sample_next;
  assign res.timed_out = done && timeout_seen;
  assign res.busy_res  = phase_next != PH_IDLE;

  `BRS_ASSERT_NEXT(a_hold_when_stalled, !step_en, $stable(clock_level) && $stable(phase), "sequencer state moved without a step")
  `BRS_ASSERT_NOW(a_done_only_from_trail, phase != PH_TRAIL_LOW, !done, "done raised outside the last trailing low half")
  `BRS_ASSERT_NEXT(a_timeout_flag_steady, phase != PH_IDLE && phase != PH_WAIT, $stable(timeout_seen), "timeout flag changed after the ready wait")
  `BRS_ASSERT_NOW(a_bit_count_bound, 1'b1, bit_count <= brs_pkg::BIT_LAST, "bit count ran past the word length")

endmodule

>>> bench/brs_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the bridge ADC readout bench: a tick-by-tick copy of the pin sequencer
// and the queue of pin states it expects. Depends on brs_pkg.
package brs_tb_pkg;
  import brs_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_WAIT, SEQ_HIGH, SEQ_LOW, SEQ_TRAIL_HIGH, SEQ_TRAIL_LOW
  } seq_phase_e;

  // Gain codes the RTL package leaves unnamed
  localparam logic [1:0] GAIN_TWO_PULSES = 2'd1;
  localparam logic [1:0] GAIN_SPARE      = 2'd3;

  class readout_scoreboard;
    logic [15:0]          half_period;
    logic [31:0]          ready_timeout;
    seq_phase_e           phase;
    logic [31:0]          tick_count;
    logic [BIT_W-1:0]     bit_count;
    logic [DATA_BITS-1:0] shift_value;
    logic [1:0]           pulses_left;
    logic                 timeout_seen;
    logic                 clock_level;
    logic [SAMPLE_W-1:0]  last_sample;
    res_t                 pin_state_q[$];
    int                   fails;
    int                   readouts;
    int                   timeouts;
    int                   ticks_checked;

    function new();
      half_period   = HALF_PERIOD_RESET;
      ready_timeout = READY_TIMEOUT_RESET;
      phase         = SEQ_IDLE;
      tick_count    = '0;
      bit_count     = '0;
      shift_value   = '0;
      pulses_left   = '0;
      timeout_seen  = 1'b0;
      clock_level   = 1'b1;
      last_sample   = '0;
      fails         = 0;
      readouts      = 0;
      timeouts      = 0;
      ticks_checked = 0;
    endfunction

    function void write_reg(logic sel, logic [31:0] value);
      if (sel == REG_HALF_PERIOD) begin
        half_period = value[15:0];
      end else begin
        ready_timeout = value;
      end
    endfunction

    // A zero half period still needs one tick, since the count is bumped first
    function bit half_done();
      tick_count = tick_count + 32'd1;
      return tick_count >= {16'd0, half_period};
    endfunction

    function void advance_tick(item_t it);
      res_t want;
      logic done;
      done = 1'b0;
      case (phase)
        SEQ_IDLE: begin
          if (it.start_req) begin
            clock_level  = 1'b0;
            phase        = SEQ_WAIT;
            tick_count   = '0;
            bit_count    = '0;
            shift_value  = '0;
            timeout_seen = 1'b0;
            pulses_left  = (it.gain_select == GAIN_ONE_PULSE)    ? 2'd1 :
                           (it.gain_select == GAIN_THREE_PULSES) ? 2'd3 : 2'd2;
          end
        end
        SEQ_WAIT: begin
          if (!it.data_pin) begin
            clock_level = 1'b1;
            phase       = SEQ_HIGH;
            tick_count  = '0;
          end else begin
            tick_count = tick_count + 32'd1;
            if (tick_count >= ready_timeout) begin
              timeout_seen = 1'b1;
              clock_level  = 1'b1;
              phase        = SEQ_HIGH;
              tick_count   = '0;
            end
          end
        end
        SEQ_HIGH: begin
          if (half_done()) begin
            clock_level = 1'b0;
            phase       = SEQ_LOW;
            tick_count  = '0;
          end
        end
        SEQ_LOW: begin
          if (half_done()) begin
            shift_value = {shift_value[DATA_BITS-2:0], it.data_pin};
            bit_count   = bit_count + BIT_ONE;
            clock_level = 1'b1;
            tick_count  = '0;
            phase       = (bit_count >= BIT_LAST) ? SEQ_TRAIL_HIGH : SEQ_HIGH;
          end
        end
        SEQ_TRAIL_HIGH: begin
          if (half_done()) begin
            clock_level = 1'b0;
            phase       = SEQ_TRAIL_LOW;
            tick_count  = '0;
          end
        end
        SEQ_TRAIL_LOW: begin
          if (half_done()) begin
            tick_count = '0;
            if (pulses_left > 2'd1) begin
              pulses_left = pulses_left - 2'd1;
              clock_level = 1'b1;
              phase       = SEQ_TRAIL_HIGH;
            end else begin
              pulses_left = '0;
              last_sample = timeout_seen ? '0 : shift_value[SAMPLE_W-1:0];
              done        = 1'b1;
              phase       = SEQ_IDLE;
              readouts++;
              if (timeout_seen) timeouts++;
            end
          end
        end
        default: phase = SEQ_IDLE;
      endcase
      want.clock_pin = clock_level;
      want.done_res  = done;
      want.sample    = last_sample;
      want.timed_out = done & timeout_seen;
      want.busy_res  = (phase != SEQ_IDLE);
      pin_state_q.push_back(want);
    endfunction

    function void check_field(string field, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        fails++;
      end
    endfunction

    function void compare_pins(logic [31:0] tdata);
      res_t got;
      res_t want;
      got = tdata[$bits(res_t)-1:0];
      if (pin_state_q.size() == 0) begin
        $error("result item with nothing expected: tdata %h", tdata);
        fails++;
        return;
      end
      want = pin_state_q.pop_front();
      ticks_checked++;
      check_field("clock_pin", 32'(want.clock_pin), 32'(got.clock_pin));
      check_field("done_res", 32'(want.done_res), 32'(got.done_res));
      check_field("sample", 32'(want.sample), 32'(got.sample));
      check_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
      check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      check_field("pad", 0, 32'(tdata[31:$bits(res_t)]));
    endfunction
  endclass

endpackage

>>> bench/bridge_adc_serial_readout_top_tb.sv
`timescale 1ns / 1ps
// Bench for bridge_adc_serial_readout_top: drives sequencer ticks and register writes,
// checks every result item against brs_tb_pkg's scoreboard. Depends on brs_pkg, brs_tb_pkg.
module bridge_adc_serial_readout_top_tb;
  import brs_pkg::*;
  import brs_tb_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // start_req[0], gain_select[2:1], data_pin[3], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // clock_pin[0], done_res[1], sample[25:2],
                                    // timed_out[26], busy_res[27], zero pad
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  readout_scoreboard sb;
  int calm[2];
  int ticks_sent;
  int settings_used;
  int cycles;

  bridge_adc_serial_readout_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit");
      $display("status: fail");
      $finish;
    end
  end

  // Side 0 is the tick sender, side 1 the result receiver
  function automatic int draw_gap(input int side);
    int r;
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm[side] = $urandom_range(30, 120);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(6, 12);
  endfunction

  initial begin : result_sink
    int gap;
    forever begin
      gap = draw_gap(1);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.compare_pins(m_axis_tdata);
  end

  // Leaves tvalid high on return so back-to-back ticks stay back to back
  task automatic send_tick(input item_t it);
    int gap;
    gap = draw_gap(0);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = {4'd0, it};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.advance_tick(it);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pin_state_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_ticks(input int n);
    item_t it;
    repeat (n) begin
      it.start_req   = 1'b0;
      it.gain_select = 2'($urandom_range(0, 3));
      it.data_pin    = 1'($urandom_range(0, 1));
      send_tick(it);
    end
  endtask

  task automatic apb_write(input logic sel, input logic [31:0] value);
    paddr   = {sel, 2'b00};
    pwdata  = value;
    pwrite  = 1'b1;
    psel    = 1'b1;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(sel, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read_check(input logic sel, input logic [31:0] want);
    paddr  = {sel, 2'b00};
    pwrite = 1'b0;
    psel   = 1'b1;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("prdata of register %0d: expected %h, got %h", sel, want, prdata);
      sb.fails++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(input logic [15:0] half, input logic [31:0] ready_to);
    drain();
    apb_write(REG_HALF_PERIOD, {16'd0, half});
    apb_write(REG_READY_TIMEOUT, ready_to);
    apb_read_check(REG_HALF_PERIOD, {16'd0, half});
    apb_read_check(REG_READY_TIMEOUT, ready_to);
    settings_used++;
  endtask

  // One conversion: the converter drops its data line after ready_after wait ticks and
  // shifts out pattern MSB first; stray_pct sets how often start is raised while busy.
  task automatic run_readout(input logic [1:0] gain, input int ready_after,
                             input logic [DATA_BITS-1:0] pattern, input int stray_pct);
    item_t it;
    int waited;
    waited         = 0;
    it.start_req   = 1'b1;
    it.gain_select = gain;
    it.data_pin    = 1'($urandom_range(0, 1));
    send_tick(it);
    while (sb.phase != SEQ_IDLE) begin
      it.start_req   = ($urandom_range(0, 99) < stray_pct);
      it.gain_select = 2'($urandom_range(0, 3));
      case (sb.phase)
        SEQ_WAIT: begin
          it.data_pin = (waited < ready_after);
          waited++;
        end
        SEQ_LOW: it.data_pin = pattern[DATA_BITS-1-int'(sb.bit_count)];
        default: it.data_pin = 1'($urandom_range(0, 1));
      endcase
      send_tick(it);
    end
  endtask

  task automatic random_phase(input logic [15:0] half, input logic [31:0] ready_to,
                              input int budget, input int ready_max);
    int first;
    int r;
    logic [DATA_BITS-1:0] pat;
    set_config(half, ready_to);
    first = ticks_sent;
    while (ticks_sent - first < budget) begin
      idle_ticks($urandom_range(0, 5));
      r   = $urandom_range(0, 7);
      pat = (r == 0) ? 24'hFFFFFF :
            (r == 1) ? 24'h800000 :
            (r == 2) ? 24'h7FFFFF :
            (r == 3) ? 24'h000000 : 24'($urandom);
      run_readout(2'($urandom_range(0, 3)), $urandom_range(0, ready_max), pat,
                  ($urandom_range(0, 3) == 0) ? 20 : 0);
      // hold off now and then until every result is back
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Reset values: clock idles high, registers read back their defaults
    idle_ticks(6);
    drain();
    apb_read_check(REG_HALF_PERIOD, {16'd0, HALF_PERIOD_RESET});
    apb_read_check(REG_READY_TIMEOUT, READY_TIMEOUT_RESET);
    settings_used = 1;

    // Zero timeout: any high tick in the wait gives up at once
    set_config(16'd1, 32'd0);
    run_readout(GAIN_ONE_PULSE, 0, 24'h800000, 0);
    run_readout(GAIN_SPARE, 0, 24'h000000, 0);
    run_readout(GAIN_TWO_PULSES, 3, 24'hC3C3C3, 0);
    // start held high for the whole readout, the finishing tick included
    run_readout(GAIN_THREE_PULSES, 0, 24'h9E3701, 100);

    // Zero half period runs as one tick per half
    set_config(16'd0, 32'd1);
    run_readout(GAIN_THREE_PULSES, 0, 24'h800001, 0);

    // Longest half period: write and read back, then idle only
    set_config(16'hFFFF, 32'd1);
    idle_ticks(20);

    random_phase(16'd1, $urandom_range(1, 6), 50, 8);
    random_phase(16'd2, 32'hFFFFFFFF, 50, 12);

    drain();
    repeat (6) @(posedge clk);
    $display("checked %0d ticks over %0d register settings", sb.ticks_checked, settings_used);
    $display("%0d readouts finished, %0d of them by ready timeout", sb.readouts, sb.timeouts);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
